// ----- sv/lrq_pkg.sv -----
// Package for the LRU recency queue.
// Holds the request and response payload types and the command sent down the cell row.
// No dependencies.
`timescale 1ns / 1ps

package lrq_pkg;

	typedef enum logic {
		OP_TOUCH = 1'b0,
		OP_POP   = 1'b1
	} lrq_op_t;

	typedef struct packed {
		lrq_op_t     operation;
		logic [15:0] value;
	} lrq_req_t;

	typedef struct packed {
		logic [15:0] popped_value;
		logic        popped_valid;
		logic        was_present;
		logic        full_reject;
		logic [15:0] front_value;
		logic [15:0] rear_value;
		logic [4:0]  entry_count;
		logic        list_empty;
	} lrq_rsp_t;

	typedef struct packed {
		logic en;
		logic touch;
		logic pop;
		logic append;
	} lrq_cmd_t;

endpackage

// ----- sv/lrq_cell.sv -----
// One slot of the recency list: holds an entry, matches it against the touched value,
// and takes its neighbor's entry if a slot at or before it goes, or a tail append.
// Depends on lrq_pkg.
`timescale 1ns / 1ps

module lrq_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 16,
	parameter int CW         = 5
) (
	input  logic                  clk,
	input  lrq_pkg::lrq_cmd_t     cmd,
	input  logic [VALUE_BITS-1:0] val,
	input  logic [CW-1:0]         cnt,
	input  logic [CW-1:0]         tail,
	input  logic                  shift_in,
	input  logic [VALUE_BITS-1:0] next_in,
	output logic                  shift_out,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] entry,
	output logic [VALUE_BITS-1:0] entry_d
);
	import lrq_pkg::*;

	localparam logic [CW-1:0] IDX_C   = CW'(IDX);
	localparam bit            IS_HEAD = (IDX == 0);

	logic [VALUE_BITS-1:0] entry_q;
	logic                  occupied;

	assign occupied  = (IDX_C < cnt);
	assign hit       = occupied && ((cmd.touch && (entry_q == val)) || (cmd.pop && IS_HEAD));
	assign shift_out = shift_in | hit;
	assign entry     = entry_q;

	always_comb begin
		if (cmd.append && (tail == IDX_C)) begin
			entry_d = val;
		end else if (shift_out) begin
			entry_d = next_in;
		end else begin
			entry_d = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			entry_q <= entry_d;
		end
	end

endmodule

// ----- sv/lru_recency_queue.sv -----
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while responses drain; the cell row searches and compacts combinationally.
// A new request is taken while the response register is empty or being drained.
// Reset (arst_n low, asynchronous) empties the list and the response register.
// Depends on lrq_pkg and lrq_cell.
`timescale 1ns / 1ps

module lru_recency_queue #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lrq_pkg::lrq_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lrq_pkg::lrq_rsp_t rsp_data
);
	import lrq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_d;
	logic [CW-1:0]         tail;
	logic [VALUE_BITS-1:0] rear_q;
	logic [VALUE_BITS-1:0] val;
	logic                  accept;
	logic                  found;
	logic                  full;
	logic                  reject;
	lrq_cmd_t              cmd;
	lrq_rsp_t              rsp_d;
	lrq_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	logic [DEPTH-1:0]                 hits;
	logic [DEPTH:0]                   shifts;
	logic [DEPTH:0][VALUE_BITS-1:0]   nexts;
	logic [DEPTH-1:0][VALUE_BITS-1:0] entries;
	logic [DEPTH-1:0][VALUE_BITS-1:0] entries_d;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign val       = VALUE_BITS'(req_data.value);

	assign full   = (cnt_q == CW'(DEPTH));
	assign found  = (req_data.operation == OP_TOUCH) && (|hits);
	assign reject = (req_data.operation == OP_TOUCH) && !found && full;

	always_comb begin
		cmd.en     = accept;
		cmd.touch  = (req_data.operation == OP_TOUCH);
		cmd.pop    = (req_data.operation == OP_POP);
		cmd.append = cmd.touch && !reject;
	end

	always_comb begin
		if (cmd.pop) begin
			cnt_d = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
		end else if (found || full) begin
			cnt_d = cnt_q;
		end else begin
			cnt_d = cnt_q + CW'(1);
		end
	end

	assign tail = cnt_d - CW'(1);

	assign shifts[0]     = 1'b0;
	assign nexts[DEPTH]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lrq_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS),
			.CW         (CW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.val       (val),
			.cnt       (cnt_q),
			.tail      (tail),
			.shift_in  (shifts[i]),
			.next_in   (nexts[i+1]),
			.shift_out (shifts[i+1]),
			.hit       (hits[i]),
			.entry     (entries[i]),
			.entry_d   (entries_d[i])
		);
		assign nexts[i] = entries[i];
	end

	always_comb begin
		rsp_d = '0;
		if (cmd.pop && (cnt_q != '0)) begin
			rsp_d.popped_value = 16'(entries[0]);
			rsp_d.popped_valid = 1'b1;
		end
		rsp_d.was_present = found;
		rsp_d.full_reject = reject;
		if (cnt_d != '0) begin
			rsp_d.front_value = 16'(entries_d[0]);
			rsp_d.rear_value  = cmd.append ? 16'(val) : 16'(rear_q);
		end
		rsp_d.entry_count = 5'(cnt_d);
		rsp_d.list_empty  = (cnt_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
			if (cmd.append) begin
				rear_q <= val;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- sv/lrq_checker.sv -----
// Port-level checks for the LRU recency queue, bound to the top level.
// Depends on lrq_pkg and lru_recency_queue.
`timescale 1ns / 1ps

module lrq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input lrq_pkg::lrq_req_t req_data,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input lrq_pkg::lrq_rsp_t rsp_data
);
	import lrq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed or dropped while stalled");

	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request produced no response");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.list_empty |->
		rsp_data.entry_count == 5'd0 && rsp_data.front_value == 16'd0
		&& rsp_data.rear_value == 16'd0)
		else $error("empty list reports contents");

	a_pop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.popped_valid |->
		!rsp_data.was_present && !rsp_data.full_reject)
		else $error("pop response carries touch flags");

	a_reject_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.full_reject |->
		!rsp_data.was_present && !rsp_data.popped_valid && rsp_data.popped_value == 16'd0)
		else $error("rejected touch carries inconsistent flags");

endmodule

bind lru_recency_queue lrq_checker u_lrq_checker (.*);
